// ===== src/wtc_pkg.sv =====
// Shared types and constants for the water heater thermostat core.
// Holds register indexes, reset values and the sample window command type.
// No dependencies.
package wtc_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;

    localparam int TEMP_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT_STEP   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND_HALF   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT_MIN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT_MAX    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTING_TIMEOUT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT_INIT   = 3'd5;

    // Register reset values.
    localparam logic [4:0] STEP_RST     = 5'd5;
    localparam logic [4:0] DEADBAND_RST = 5'd5;
    localparam logic [7:0] SP_MIN_RST   = 8'd35;
    localparam logic [7:0] SP_MAX_RST   = 8'd75;
    localparam logic [7:0] TIMEOUT_RST  = 8'd5;
    localparam logic [7:0] SP_INIT_RST  = 8'd60;

    // Command from the control logic to the averaging window.
    typedef struct packed {
        logic              take;
        logic [TEMP_W-1:0] temp;
    } t_win_cmd;

endpackage

// ===== src/wtc_window.sv =====
// Moving-average sample window for the thermostat core.
// Keeps the samples in a small memory with a running sum; uses wtc_pkg.
// The first sample after reset stands for every entry until overwritten.
module wtc_window #(
    parameter int WINDOW_DEPTH = wtc_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wtc_pkg::t_win_cmd              i_cmd,
    output logic [wtc_pkg::TEMP_W-1:0]     o_avg_next
);

    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = PTR_W + wtc_pkg::TEMP_W;
    localparam bit IS_POW2 = ((1 << PTR_W) == WINDOW_DEPTH);

    logic [wtc_pkg::TEMP_W-1:0] r_mem [WINDOW_DEPTH];
    logic [wtc_pkg::TEMP_W-1:0] r_rd;
    logic [wtc_pkg::TEMP_W-1:0] r_prime_val;
    logic [PTR_W-1:0]           r_ptr, n_ptr;
    logic                       r_primed, n_primed;
    logic                       r_full, n_full;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic [wtc_pkg::TEMP_W-1:0] old_val;
    logic                       ptr_last;

    assign ptr_last = (r_ptr == PTR_W'(WINDOW_DEPTH - 1));

    // Until the pointer has wrapped once, the entry about to be replaced
    // still holds the priming sample.
    assign old_val = r_full ? r_rd : r_prime_val;

    always_comb begin
        n_ptr    = r_ptr;
        n_primed = r_primed;
        n_full   = r_full;
        n_sum    = r_sum;
        if (i_cmd.take) begin
            if (!r_primed) begin
                n_primed = 1'b1;
                n_ptr    = '0;
                n_sum    = SUM_W'(i_cmd.temp) * SUM_W'(WINDOW_DEPTH);
            end else begin
                n_sum  = r_sum - SUM_W'(old_val) + SUM_W'(i_cmd.temp);
                n_ptr  = ptr_last ? '0 : r_ptr + 1'b1;
                n_full = r_full | ptr_last;
            end
        end
    end

    generate
        if (IS_POW2) begin : g_shift
            assign o_avg_next = n_sum[SUM_W-1:PTR_W];
        end else begin : g_recip
            // Exact floor division by a constant through a scaled reciprocal.
            localparam int DIV_K = SUM_W + PTR_W;
            localparam int DIV_M = ((1 << DIV_K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
            logic [SUM_W+DIV_K-1:0] prod;
            assign prod       = (SUM_W + DIV_K)'(n_sum) * (SUM_W + DIV_K)'(DIV_M);
            assign o_avg_next = prod[DIV_K +: wtc_pkg::TEMP_W];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_primed <= 1'b0;
            r_full   <= 1'b0;
            r_sum    <= '0;
        end else begin
            r_ptr    <= n_ptr;
            r_primed <= n_primed;
            r_full   <= n_full;
            r_sum    <= n_sum;
        end
    end

    // Sample store and registered read of the next entry to be replaced.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && r_primed) begin
            r_mem[r_ptr] <= i_cmd.temp;
        end
        if (i_cmd.take && !r_primed) begin
            r_prime_val <= i_cmd.temp;
        end
        r_rd <= r_mem[n_ptr];
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(WINDOW_DEPTH - 1))
        else $error("window pointer out of range");

    a_full_after_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> (!r_full && r_ptr == '0))
        else $error("window filled or advanced before priming");

endmodule

// ===== src/water_heater_thermostat_core.sv =====
// Thermostat core: each accepted input beat gives a registered result beat in the next cycle.
// Throughput is one beat per cycle while results are taken; each event updates all state at once,
// with the window sum update, the average and the band compare in one path.
// A result that waits holds off the input, which moves again in the cycle it is taken.
// Reset is synchronous and active low; it clears control state and loads the registers'
// reset values. The sample store is not cleared: the first sample fills the window.
module water_heater_thermostat_core #(
    parameter int WINDOW_DEPTH = wtc_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [wtc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [wtc_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_operation,
    input  logic [7:0]                         i_temperature,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_mode,
    output logic                               o_heater_on,
    output logic                               o_cooler_on,
    output logic                               o_lamp_on,
    output logic [7:0]                         o_average_temp,
    output logic [7:0]                         o_setpoint
);

    typedef enum logic [2:0] {
        MODE_OFF     = 3'b001,
        MODE_NORMAL  = 3'b010,
        MODE_SETTING = 3'b100
    } t_mode;

    localparam logic [2:0] OP_SAMPLE = 3'd0;
    localparam logic [2:0] OP_UP     = 3'd1;
    localparam logic [2:0] OP_DOWN   = 3'd2;
    localparam logic [2:0] OP_POWER  = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [1:0] CODE_OFF     = 2'd0;
    localparam logic [1:0] CODE_NORMAL  = 2'd1;
    localparam logic [1:0] CODE_SETTING = 2'd2;

    typedef struct packed {
        logic heat;
        logic cool;
        logic lamp;
    } t_drive;

    // Configuration registers
    logic [4:0] r_step;
    logic [4:0] r_band;
    logic [7:0] r_sp_min;
    logic [7:0] r_sp_max;
    logic [7:0] r_timeout;

    // Block state
    t_mode      r_mode, n_mode;
    logic [7:0] r_desired, n_desired;
    logic [7:0] r_avg, n_avg;
    t_drive     r_drv, n_drv;
    logic [7:0] r_idle, n_idle;

    // Result register
    logic       r_out_valid;
    logic [1:0] r_out_mode;
    t_drive     r_out_drv;
    logic [7:0] r_out_avg;
    logic [7:0] r_out_sp;

    logic              accept;
    logic              is_normal;
    wtc_pkg::t_win_cmd win_cmd;
    logic [7:0]        win_avg;
    logic [8:0]        up_sum;
    logic [7:0]        idle_inc;
    logic              cool_side;
    logic              heat_side;
    logic [1:0]        n_code;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_normal  = (r_mode == MODE_NORMAL);

    assign win_cmd = '{take: accept && (i_operation == OP_SAMPLE) && is_normal,
                       temp: i_temperature};

    wtc_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (win_cmd),
        .o_avg_next(win_avg)
    );

    // Band tests against the new average: d < a + h and d > a - h.
    assign cool_side = {1'b0, r_desired} < ({1'b0, win_avg} + 9'(r_band));
    assign heat_side = ({1'b0, r_desired} + 9'(r_band)) > {1'b0, win_avg};

    assign up_sum   = {1'b0, r_desired} + 9'(r_step);
    assign idle_inc = (r_idle == 8'hFF) ? r_idle : r_idle + 8'd1;

    always_comb begin
        n_mode    = r_mode;
        n_desired = r_desired;
        n_avg     = r_avg;
        n_drv     = r_drv;
        n_idle    = r_idle;
        if (accept) begin
            unique case (i_operation)
                OP_SAMPLE: begin
                    if (is_normal) begin
                        n_avg = win_avg;
                        priority if (cool_side && heat_side) begin
                            n_drv = '0;
                        end else if (cool_side) begin
                            n_drv = '{heat: 1'b0, cool: 1'b1, lamp: 1'b1};
                        end else if (heat_side) begin
                            n_drv = '{heat: 1'b1, cool: 1'b0, lamp: r_drv.lamp};
                        end else begin
                            n_drv = r_drv;
                        end
                    end
                end
                OP_UP, OP_DOWN: begin
                    unique case (r_mode)
                        MODE_NORMAL: begin
                            n_mode = MODE_SETTING;
                            n_drv  = '0;
                            n_idle = '0;
                        end
                        MODE_SETTING: begin
                            n_idle = '0;
                            if (i_operation == OP_UP) begin
                                if (r_desired < r_sp_max) begin
                                    n_desired = up_sum[8] ? 8'hFF : up_sum[7:0];
                                end
                            end else if (r_desired > r_sp_min) begin
                                n_desired = (r_desired > 8'(r_step)) ?
                                            r_desired - 8'(r_step) : 8'd0;
                            end
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase
                end
                OP_POWER: begin
                    if (r_mode == MODE_OFF) begin
                        n_mode = MODE_NORMAL;
                    end else begin
                        n_mode = MODE_OFF;
                        n_drv  = '0;
                    end
                    n_idle = '0;
                end
                OP_TICK: begin
                    unique case (r_mode)
                        MODE_NORMAL: begin
                            if (r_drv.heat) begin
                                n_drv.lamp = !r_drv.lamp;
                            end
                        end
                        MODE_SETTING: begin
                            if (idle_inc >= r_timeout) begin
                                n_mode = MODE_NORMAL;
                                n_idle = '0;
                            end else begin
                                n_idle = idle_inc;
                            end
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
        // Loading a new initial setpoint takes effect at once.
        if (i_cfg_wr_en && i_cfg_addr == wtc_pkg::CFG_SETPOINT_INIT) begin
            n_desired = i_cfg_wr_data;
        end
    end

    always_comb begin
        unique case (n_mode)
            MODE_NORMAL:  n_code = CODE_NORMAL;
            MODE_SETTING: n_code = CODE_SETTING;
            default:      n_code = CODE_OFF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= wtc_pkg::STEP_RST;
            r_band    <= wtc_pkg::DEADBAND_RST;
            r_sp_min  <= wtc_pkg::SP_MIN_RST;
            r_sp_max  <= wtc_pkg::SP_MAX_RST;
            r_timeout <= wtc_pkg::TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                wtc_pkg::CFG_SETPOINT_STEP:   r_step    <= i_cfg_wr_data[4:0];
                wtc_pkg::CFG_DEADBAND_HALF:   r_band    <= i_cfg_wr_data[4:0];
                wtc_pkg::CFG_SETPOINT_MIN:    r_sp_min  <= i_cfg_wr_data;
                wtc_pkg::CFG_SETPOINT_MAX:    r_sp_max  <= i_cfg_wr_data;
                wtc_pkg::CFG_SETTING_TIMEOUT: r_timeout <= i_cfg_wr_data;
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_desired   <= wtc_pkg::SP_INIT_RST;
            r_avg       <= '0;
            r_drv       <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_desired <= n_desired;
            r_avg     <= n_avg;
            r_drv     <= n_drv;
            r_idle    <= n_idle;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_mode <= n_code;
            r_out_drv  <= n_drv;
            r_out_avg  <= n_avg;
            r_out_sp   <= n_desired;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode         = r_out_mode;
    assign o_heater_on    = r_out_drv.heat;
    assign o_cooler_on    = r_out_drv.cool;
    assign o_lamp_on      = r_out_drv.lamp;
    assign o_average_temp = r_out_avg;
    assign o_setpoint     = r_out_sp;

    a_no_heat_and_cool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_drv.heat && r_drv.cool))
        else $error("heater and cooler driven together");

    a_drives_off_unless_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_NORMAL) |-> (r_drv == '0))
        else $error("drive active outside normal mode");

    a_idle_only_in_setting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_SETTING) |-> (r_idle == '0))
        else $error("idle counter running outside setting mode");

    a_result_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted beat produced no result");

    a_setpoint_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && i_cfg_addr == wtc_pkg::CFG_SETPOINT_INIT)
        |=> (r_desired == $past(i_cfg_wr_data)))
        else $error("initial setpoint write not loaded");

endmodule

// ===== verif/wtc_status_checker.sv =====
// Status checker for the water heater thermostat core: event and mode codes, plus a
// module that follows both channels, predicts every result beat and compares it.
// Depends on wtc_pkg for the register indexes and the window depth.
package wtc_tb_pkg;

    typedef enum logic [2:0] {
        EV_SAMPLE = 3'd0,
        EV_UP     = 3'd1,
        EV_DOWN   = 3'd2,
        EV_POWER  = 3'd3,
        EV_TICK   = 3'd4,
        EV_SPARE5 = 3'd5,
        EV_SPARE6 = 3'd6,
        EV_SPARE7 = 3'd7
    } event_e;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_NORMAL  = 2'd1,
        MODE_SETTING = 2'd2
    } mode_e;

    // Register indexes that decode to nothing.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic       heat;
        logic       cool;
        logic       lamp;
        logic [7:0] avg;
        logic [7:0] setpoint;
    } status_t;

endpackage

module wtc_status_checker
    import wtc_tb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_temperature,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_mode,
    input  logic       i_heater_on,
    input  logic       i_cooler_on,
    input  logic       i_lamp_on,
    input  logic [7:0] i_average_temp,
    input  logic [7:0] i_setpoint,
    output int         o_fail_count,
    output int         o_pending_count
);

    localparam int DEPTH = wtc_pkg::WINDOW_DEPTH_DEF;

    localparam logic [4:0] STEP_AT_RESET     = 5'd5;
    localparam logic [4:0] BAND_AT_RESET     = 5'd5;
    localparam logic [7:0] MIN_AT_RESET      = 8'd35;
    localparam logic [7:0] MAX_AT_RESET      = 8'd75;
    localparam logic [7:0] TIMEOUT_AT_RESET  = 8'd5;
    localparam logic [7:0] SETPOINT_AT_RESET = 8'd60;

    logic [4:0] step_r;
    logic [4:0] band_r;
    logic [7:0] sp_min_r;
    logic [7:0] sp_max_r;
    logic [7:0] timeout_r;

    mode_e      mode_q;
    logic [7:0] setpoint_q;
    logic [7:0] avg_q;
    logic [7:0] idle_q;
    logic [7:0] window_q [DEPTH];
    int         wr_ptr_q;
    int         sum_q;
    logic       primed_q;
    logic       heat_q;
    logic       cool_q;
    logic       lamp_q;

    status_t    predicted_status [$];
    int         beat_count;

    task automatic report_mismatch(input string what);
        $display("MISMATCH result beat %0d: %s", beat_count, what);
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic advance_thermostat(input event_e ev, input logic [7:0] temp);
        int d;
        int a;
        int h;
        int raised;
        case (ev)
            EV_SAMPLE: begin
                if (mode_q == MODE_NORMAL) begin
                    // The first reading after reset stands for the whole window.
                    if (!primed_q) begin
                        for (int i = 0; i < DEPTH; i++) window_q[i] = temp;
                        sum_q    = DEPTH * int'(temp);
                        wr_ptr_q = 0;
                        primed_q = 1'b1;
                    end else begin
                        sum_q = sum_q - int'(window_q[wr_ptr_q]) + int'(temp);
                        window_q[wr_ptr_q] = temp;
                        wr_ptr_q = (wr_ptr_q + 1) % DEPTH;
                    end
                    avg_q = 8'(sum_q / DEPTH);

                    d = int'(setpoint_q);
                    a = int'(avg_q);
                    h = int'(band_r);
                    if (d < a + h && d > a - h) begin
                        heat_q = 1'b0;
                        cool_q = 1'b0;
                        lamp_q = 1'b0;
                    end else if (d < a + h) begin
                        heat_q = 1'b0;
                        cool_q = 1'b1;
                        lamp_q = 1'b1;
                    end else if (d > a - h) begin
                        heat_q = 1'b1;
                        cool_q = 1'b0;
                    end
                    // With no band and the setpoint right on the average, drives hold.
                end
            end
            EV_UP, EV_DOWN: begin
                if (mode_q == MODE_NORMAL) begin
                    mode_q = MODE_SETTING;
                    heat_q = 1'b0;
                    cool_q = 1'b0;
                    lamp_q = 1'b0;
                    idle_q = 8'd0;
                end else if (mode_q == MODE_SETTING) begin
                    idle_q = 8'd0;
                    if (ev == EV_UP && setpoint_q < sp_max_r) begin
                        raised = int'(setpoint_q) + int'(step_r);
                        setpoint_q = (raised > 255) ? 8'd255 : 8'(raised);
                    end else if (ev == EV_DOWN && setpoint_q > sp_min_r) begin
                        setpoint_q = (setpoint_q > 8'(step_r)) ? setpoint_q - 8'(step_r) : 8'd0;
                    end
                end
            end
            EV_POWER: begin
                if (mode_q == MODE_OFF) begin
                    mode_q = MODE_NORMAL;
                end else begin
                    mode_q = MODE_OFF;
                    heat_q = 1'b0;
                    cool_q = 1'b0;
                    lamp_q = 1'b0;
                end
                idle_q = 8'd0;
            end
            EV_TICK: begin
                if (mode_q == MODE_NORMAL) begin
                    if (heat_q) lamp_q = !lamp_q;
                end else if (mode_q == MODE_SETTING) begin
                    if (idle_q != 8'd255) idle_q = idle_q + 8'd1;
                    if (idle_q >= timeout_r) begin
                        mode_q = MODE_NORMAL;
                        idle_q = 8'd0;
                    end
                end
            end
            default: begin
            end
        endcase
        predicted_status.push_back('{mode: mode_q, heat: heat_q, cool: cool_q, lamp: lamp_q,
                                     avg: avg_q, setpoint: setpoint_q});
    endtask

    always @(posedge i_clk) begin : track
        status_t want;
        if (!i_rst_n) begin
            step_r     = STEP_AT_RESET;
            band_r     = BAND_AT_RESET;
            sp_min_r   = MIN_AT_RESET;
            sp_max_r   = MAX_AT_RESET;
            timeout_r  = TIMEOUT_AT_RESET;
            mode_q     = MODE_OFF;
            setpoint_q = SETPOINT_AT_RESET;
            avg_q      = 8'd0;
            idle_q     = 8'd0;
            wr_ptr_q   = 0;
            sum_q      = 0;
            primed_q   = 1'b0;
            heat_q     = 1'b0;
            cool_q     = 1'b0;
            lamp_q     = 1'b0;
            predicted_status.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    wtc_pkg::CFG_SETPOINT_STEP:   step_r    = i_cfg_wr_data[4:0];
                    wtc_pkg::CFG_DEADBAND_HALF:   band_r    = i_cfg_wr_data[4:0];
                    wtc_pkg::CFG_SETPOINT_MIN:    sp_min_r  = i_cfg_wr_data;
                    wtc_pkg::CFG_SETPOINT_MAX:    sp_max_r  = i_cfg_wr_data;
                    wtc_pkg::CFG_SETTING_TIMEOUT: timeout_r = i_cfg_wr_data;
                    wtc_pkg::CFG_SETPOINT_INIT:   setpoint_q = i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end

            // Retire the result beat first so that it never meets its own input beat.
            if (i_out_valid && i_out_ready) begin
                if (predicted_status.size() == 0) begin
                    report_mismatch("result beat with no event waiting for it");
                end else begin
                    want = predicted_status.pop_front();
                    if (i_mode !== want.mode)
                        report_mismatch($sformatf("mode %0d, expected %0d", i_mode, want.mode));
                    if (i_heater_on !== want.heat)
                        report_mismatch($sformatf("heater %b, expected %b",
                                                  i_heater_on, want.heat));
                    if (i_cooler_on !== want.cool)
                        report_mismatch($sformatf("cooler %b, expected %b",
                                                  i_cooler_on, want.cool));
                    if (i_lamp_on !== want.lamp)
                        report_mismatch($sformatf("lamp %b, expected %b", i_lamp_on, want.lamp));
                    if (i_average_temp !== want.avg)
                        report_mismatch($sformatf("average %0d, expected %0d",
                                                  i_average_temp, want.avg));
                    if (i_setpoint !== want.setpoint)
                        report_mismatch($sformatf("setpoint %0d, expected %0d",
                                                  i_setpoint, want.setpoint));
                end
                beat_count = beat_count + 1;
            end

            if (i_in_valid && i_in_ready)
                advance_thermostat(event_e'(i_operation), i_temperature);
        end
        o_pending_count <= predicted_status.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the thermostat core testbench: clock, reset, register setup, event stimulus
// and result back-pressure, with the verdict taken from wtc_status_checker.
// Depends on wtc_pkg, wtc_tb_pkg and water_heater_thermostat_core.
module tb_top;
    import wtc_pkg::*;
    import wtc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_wr_en    = 1'b0;
    logic [2:0] cfg_addr     = 3'd0;
    logic [7:0] cfg_wr_data  = 8'd0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [2:0] operation    = 3'd0;
    logic [7:0] temperature  = 8'd0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [1:0] mode;
    logic       heater_on;
    logic       cooler_on;
    logic       lamp_on;
    logic [7:0] average_temp;
    logic [7:0] setpoint;

    int         fail_count;
    int         pending_count;
    int         cycle_count  = 0;
    mode_e      seen_mode    = MODE_OFF;
    bit         tx_calm      = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    water_heater_thermostat_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (operation),
        .i_temperature  (temperature),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_mode         (mode),
        .o_heater_on    (heater_on),
        .o_cooler_on    (cooler_on),
        .o_lamp_on      (lamp_on),
        .o_average_temp (average_temp),
        .o_setpoint     (setpoint)
    );

    wtc_status_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_operation     (operation),
        .i_temperature   (temperature),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_mode          (mode),
        .i_heater_on     (heater_on),
        .i_cooler_on     (cooler_on),
        .i_lamp_on       (lamp_on),
        .i_average_temp  (average_temp),
        .i_setpoint      (setpoint),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("water_heater_thermostat_core regression: fail");
            $finish;
        end
    end

    // The last mode seen on the result side steers the random events.
    always @(posedge clk) begin
        if (out_valid && out_ready) seen_mode <= mode_e'(mode);
    end

    // Result side: a random stall before each beat, with calm stretches of none.
    initial begin : result_sink
        int unsigned stall;
        bit          calm;
        calm = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_event(input event_e ev, input logic [7:0] temp);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= ev;
        temperature <= temp;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_event();
        int unsigned r;
        event_e      ev;
        logic [7:0]  temp;
        r = $urandom_range(0, 99);
        if (seen_mode == MODE_OFF && r < 50) begin
            ev = EV_POWER;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 48)      ev = EV_SAMPLE;
            else if (r < 57) ev = EV_UP;
            else if (r < 66) ev = EV_DOWN;
            else if (r < 69) ev = EV_POWER;
            else if (r < 95) ev = EV_TICK;
            else             ev = event_e'($urandom_range(5, 7));
        end
        // Half the readings stay near the usual setpoints so the band gets crossed.
        temp = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(20, 100));
        send_event(ev, temp);
    endtask

    // Holds off new events until every outstanding result beat has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [7:0] step_v, input logic [7:0] band_v,
                                input logic [7:0] min_v, input logic [7:0] max_v,
                                input logic [7:0] timeout_v, input logic [7:0] init_v);
        write_reg(CFG_SETPOINT_STEP, step_v);
        write_reg(CFG_DEADBAND_HALF, band_v);
        write_reg(CFG_SETPOINT_MIN, min_v);
        write_reg(CFG_SETPOINT_MAX, max_v);
        write_reg(CFG_SETTING_TIMEOUT, timeout_v);
        write_reg(CFG_SETPOINT_INIT, init_v);
        // Writes to the unused indexes must leave every register alone.
        write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
        write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: events while off, first reading, lamp blink, band
        // crossings, setpoint steps and the return to normal on idle seconds.
        send_event(EV_SAMPLE, 8'd100);
        send_event(EV_TICK, 8'd0);
        send_event(EV_UP, 8'd0);
        send_event(EV_SPARE5, 8'd255);
        send_event(EV_POWER, 8'd0);
        send_event(EV_SAMPLE, 8'd0);
        send_event(EV_TICK, 8'd0);
        repeat (4) send_event(EV_SAMPLE, 8'd255);
        send_event(EV_DOWN, 8'd0);
        send_event(EV_DOWN, 8'd0);
        send_event(EV_UP, 8'd0);
        send_event(EV_SAMPLE, 8'd200);
        repeat (5) send_event(EV_TICK, 8'd0);
        send_event(EV_POWER, 8'd0);

        // No band, with the average brought back onto the setpoint while cooling;
        // the step register is written with its upper bits set.
        drain();
        program_regs(8'hFF, 8'd0, 8'd0, 8'd255, 8'd0, 8'd127);
        send_event(EV_POWER, 8'd0);
        send_event(EV_SAMPLE, 8'd255);
        repeat (4) send_event(EV_SAMPLE, 8'd0);
        send_event(EV_TICK, 8'd0);
        send_event(EV_DOWN, 8'd0);
        send_event(EV_DOWN, 8'd0);
        send_event(EV_UP, 8'd0);
        send_event(EV_UP, 8'd0);
        send_event(EV_TICK, 8'd0);

        for (int phase = 2; phase < 10; phase++) begin
            drain();
            case (phase)
                2: program_regs(8'hFF, 8'hFF, 8'd255, 8'd0, 8'd255, 8'd255);
                3: program_regs(8'd1, 8'd1, 8'd0, 8'd255, 8'd1, 8'd0);
                4: program_regs(8'd5, 8'd5, 8'd35, 8'd75, 8'd5, 8'd60);
                default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 120)), 8'($urandom_range(100, 255)),
                                      8'($urandom_range(0, 8)), 8'($urandom_range(0, 255)));
            endcase
            if (phase == 2) begin
                // The longest idle timeout, with the idle counter reaching saturation.
                send_event(EV_UP, 8'd0);
                repeat (255) send_event(EV_TICK, 8'($urandom_range(0, 255)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 149) == 0) drain();
                send_random_event();
            end
        end

        drain();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("water_heater_thermostat_core regression: pass");
        else
            $display("water_heater_thermostat_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/wtc_pkg.sv
src/wtc_window.sv
src/water_heater_thermostat_core.sv
verif/wtc_status_checker.sv
verif/tb_top.sv
